@@ sv/assert_macros.svh @@
// Assertion macros used by the back end of the LED cube scan driver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ sv/lcpsd_pkg.sv @@
// Package with the types, constants and scan-order function of the LED cube scan driver.
package lcpsd_pkg;

    localparam int NUM_LEDS       = 128;
    localparam int ADDR_W         = $clog2(NUM_LEDS);
    localparam int COLOR_W        = 8;
    localparam int RGB_W          = 3 * COLOR_W;
    localparam int WORD_W         = 13;
    localparam int LAYERS         = 8;
    localparam int LAYER_W        = $clog2(LAYERS);
    localparam int WC_W           = 6;
    localparam int SHIFT_W        = 8;
    localparam int SLOT_W         = 7;
    localparam int BRIGHT_W       = 4;
    localparam int PREV_W         = 6;
    localparam logic [WC_W-1:0]   DATA_WORDS     = WC_W'(33);
    localparam logic [PREV_W-1:0] PREV_RESET     = PREV_W'(32);

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_FILL  = 2'd3
    } action_t;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_READ   = 1'b1
    } kind_t;

    typedef struct packed {
        action_t             action;
        logic [ADDR_W-1:0]   addr;
        logic [RGB_W-1:0]    rgb;
    } cmd_t;

    // Base layer of each group of four scan positions.
    function automatic logic [LAYER_W-1:0] z_base(input logic [1:0] sel);
        logic [LAYER_W-1:0] z;
        case (sel)
            2'd0:    z = LAYER_W'(2);
            2'd1:    z = LAYER_W'(6);
            2'd2:    z = LAYER_W'(4);
            default: z = LAYER_W'(0);
        endcase
        return z;
    endfunction

    // Frame address of the LED at a scan position; position 128 aliases position 0.
    function automatic logic [ADDR_W-1:0] scan_address(input logic [SHIFT_W-1:0] pos);
        logic [LAYER_W-1:0] z;
        z = z_base(pos[3:2]) + LAYER_W'(pos[6]);
        return {z, pos[5:4], pos[1:0]};
    endfunction

endpackage

@@ sv/lcpsd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lcpsd_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/lcpsd_front.sv @@
// Front end: accepts input beats, decodes them into commands and queues up to two of them.
module lcpsd_front
    import lcpsd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          action,
    input  logic [2:0]          layer_z,
    input  logic [1:0]          column_x,
    input  logic [1:0]          row_y,
    input  logic [COLOR_W-1:0]  red_in,
    input  logic [COLOR_W-1:0]  green_in,
    input  logic [COLOR_W-1:0]  blue_in,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output cmd_t                cmd
);

    cmd_t       queue_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       in_cmd;
    logic       push, pop;

    // The frame address is z*16 + x*4 + y.
    always_comb
    begin
        in_cmd.action = action_t'(action);
        in_cmd.addr   = {layer_z, column_x, row_y};
        in_cmd.rgb    = {red_in, green_in, blue_in};
    end

    assign in_ready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

@@ sv/lcpsd_back.sv @@
// Back end: executes commands on the frame store, runs the scan counters and drives results.
module lcpsd_back
    import lcpsd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  cmd_t                cmd,
    output logic                ram_we,
    output logic [ADDR_W-1:0]   ram_waddr,
    output logic [RGB_W-1:0]    ram_wdata,
    output logic                ram_re,
    output logic [ADDR_W-1:0]   ram_raddr,
    input  logic [RGB_W-1:0]    ram_rdata,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                reply_kind,
    output logic [WORD_W-1:0]   sample_word,
    output logic [COLOR_W-1:0]  read_red,
    output logic [COLOR_W-1:0]  read_green,
    output logic [COLOR_W-1:0]  read_blue
);

    `include "assert_macros.svh"

    typedef enum logic {
        ST_RUN,
        ST_FILL
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    fill_addr_reg, fill_addr_next;
    logic [RGB_W-1:0]     fill_rgb_reg, fill_rgb_next;
    logic [NUM_LEDS-1:0]  valid_reg, valid_next;

    logic [WC_W-1:0]      wc_reg, wc_next;
    logic                 phase_reg, phase_next;
    logic [SHIFT_W-1:0]   shift_reg, shift_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [BRIGHT_W-1:0]  bright_reg, bright_next;
    logic [LAYERS-1:0]    en_reg, en_next;
    logic [PREV_W-1:0]    prev_reg, prev_next;

    logic                 s2_valid_reg, s2_valid_next;
    kind_t                s2_kind_reg, s2_kind_next;
    logic [WORD_W-1:0]    s2_word_reg, s2_word_next;
    logic                 s2_color_reg, s2_color_next;
    logic [BRIGHT_W-1:0]  s2_bright_reg, s2_bright_next;
    logic                 s2_hit_reg, s2_hit_next;

    logic                 out_valid_reg, out_valid_next;
    kind_t                out_kind_reg, out_kind_next;
    logic [WORD_W-1:0]    out_word_reg, out_word_next;
    logic [RGB_W-1:0]     out_rgb_reg, out_rgb_next;

    logic                 s2_move, issue, is_tick, is_read, is_data_word;
    logic [LAYER_W-1:0]   new_layer;
    logic [SLOT_W-1:0]    slot_inc;
    logic [RGB_W-1:0]     entry;
    logic [WORD_W-1:0]    s2_result;

    assign s2_move      = s2_valid_reg && (!out_valid_reg || out_ready);
    assign issue        = (state_reg == ST_RUN) && cmd_valid && (!s2_valid_reg || s2_move);
    assign cmd_ready    = issue;
    assign is_tick      = (cmd.action == ACT_TICK);
    assign is_read      = (cmd.action == ACT_READ);
    assign is_data_word = (wc_reg < DATA_WORDS);
    assign slot_inc     = slot_reg + SLOT_W'(1);
    assign new_layer    = slot_inc[SLOT_W-1 -: LAYER_W];

    // Frame store port control.
    always_comb
    begin
        ram_we    = (state_reg == ST_FILL) || (issue && (cmd.action == ACT_WRITE));
        ram_waddr = (state_reg == ST_FILL) ? fill_addr_reg : cmd.addr;
        ram_wdata = (state_reg == ST_FILL) ? fill_rgb_reg : cmd.rgb;
        ram_re    = issue && (is_read || (is_tick && is_data_word));
        ram_raddr = is_read ? cmd.addr : scan_address(shift_reg);
    end

    // Entries not yet written since reset read as zero.
    assign entry = s2_hit_reg ? ram_rdata : '0;

    always_comb
    begin
        s2_result = s2_word_reg;
        if (s2_color_reg)
        begin
            s2_result[1] = ({4'd0, s2_bright_reg} < entry[23:16]);
            s2_result[2] = ({4'd0, s2_bright_reg} < entry[15:8]);
            s2_result[3] = ({4'd0, s2_bright_reg} < entry[7:0]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_addr_next = fill_addr_reg;
        fill_rgb_next  = fill_rgb_reg;
        valid_next     = valid_reg;
        wc_next        = wc_reg;
        phase_next     = phase_reg;
        shift_next     = shift_reg;
        slot_next      = slot_reg;
        bright_next    = bright_reg;
        en_next        = en_reg;
        prev_next      = prev_reg;
        s2_valid_next  = s2_valid_reg;
        s2_kind_next   = s2_kind_reg;
        s2_word_next   = s2_word_reg;
        s2_color_next  = s2_color_reg;
        s2_bright_next = s2_bright_reg;
        s2_hit_next    = s2_hit_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_word_next  = out_word_reg;
        out_rgb_next   = out_rgb_reg;

        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end

        // Output register: load from the second stage or drain.
        if (s2_move)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = s2_kind_reg;
            out_word_next  = (s2_kind_reg == KIND_SAMPLE) ? s2_result : '0;
            out_rgb_next   = (s2_kind_reg == KIND_READ) ? entry : '0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (s2_move)
        begin
            s2_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_RUN:
            begin
                if (issue)
                begin
                    unique case (cmd.action)
                        ACT_TICK:
                        begin
                            s2_valid_next  = 1'b1;
                            s2_kind_next   = KIND_SAMPLE;
                            s2_bright_next = bright_reg;
                            s2_hit_next    = valid_reg[ram_raddr];
                            if (is_data_word)
                            begin
                                s2_color_next = 1'b1;
                                s2_word_next  = {en_reg, 1'b0, 3'b000, phase_reg};
                                phase_next    = ~phase_reg;
                                if (phase_reg)
                                begin
                                    shift_next = shift_reg + SHIFT_W'(1);
                                end
                                wc_next = wc_reg + WC_W'(1);
                            end
                            else
                            begin
                                // Latch word ends the sub-frame and selects the layer for the next one.
                                s2_color_next = 1'b0;
                                slot_next     = slot_inc;
                                shift_next    = {1'b0, new_layer, 4'b0000};
                                en_next       = LAYERS'(1) << new_layer;
                                phase_next    = 1'b0;
                                wc_next       = WC_W'(1);
                                if (prev_reg != PREV_W'(new_layer))
                                begin
                                    prev_next    = PREV_W'(new_layer);
                                    bright_next  = '0;
                                    s2_word_next = {8'd0, 1'b1, 4'b0000};
                                end
                                else
                                begin
                                    bright_next  = bright_reg + BRIGHT_W'(1);
                                    s2_word_next = {LAYERS'(1) << new_layer, 1'b1, 4'b0000};
                                end
                            end
                        end
                        ACT_READ:
                        begin
                            s2_valid_next = 1'b1;
                            s2_kind_next  = KIND_READ;
                            s2_color_next = 1'b0;
                            s2_word_next  = '0;
                            s2_hit_next   = valid_reg[ram_raddr];
                        end
                        ACT_WRITE:
                        begin
                        end
                        ACT_FILL:
                        begin
                            state_next     = ST_FILL;
                            fill_addr_next = '0;
                            fill_rgb_next  = cmd.rgb;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                fill_addr_next = fill_addr_reg + ADDR_W'(1);
                if (fill_addr_reg == '1)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            fill_addr_reg <= '0;
            fill_rgb_reg  <= '0;
            valid_reg     <= '0;
            wc_reg        <= '0;
            phase_reg     <= 1'b0;
            shift_reg     <= '0;
            slot_reg      <= '0;
            bright_reg    <= '0;
            en_reg        <= '0;
            prev_reg      <= PREV_RESET;
            s2_valid_reg  <= 1'b0;
            s2_kind_reg   <= KIND_SAMPLE;
            s2_word_reg   <= '0;
            s2_color_reg  <= 1'b0;
            s2_bright_reg <= '0;
            s2_hit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_SAMPLE;
            out_word_reg  <= '0;
            out_rgb_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_addr_reg <= fill_addr_next;
            fill_rgb_reg  <= fill_rgb_next;
            valid_reg     <= valid_next;
            wc_reg        <= wc_next;
            phase_reg     <= phase_next;
            shift_reg     <= shift_next;
            slot_reg      <= slot_next;
            bright_reg    <= bright_next;
            en_reg        <= en_next;
            prev_reg      <= prev_next;
            s2_valid_reg  <= s2_valid_next;
            s2_kind_reg   <= s2_kind_next;
            s2_word_reg   <= s2_word_next;
            s2_color_reg  <= s2_color_next;
            s2_bright_reg <= s2_bright_next;
            s2_hit_reg    <= s2_hit_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_word_reg  <= out_word_next;
            out_rgb_reg   <= out_rgb_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign reply_kind  = out_kind_reg;
    assign sample_word = out_word_reg;
    assign read_red    = out_rgb_reg[23:16];
    assign read_green  = out_rgb_reg[15:8];
    assign read_blue   = out_rgb_reg[7:0];

    `ASSERT_IMPL(a_fill_blocks_issue, (state_reg == ST_FILL), !issue,
        "command issued during fill sweep")
    `ASSERT_IMPL(a_stage2_stall_blocks_issue, (s2_valid_reg && !s2_move), !issue,
        "command issued while second stage is stalled")
    `ASSERT_IMPL(a_one_layer_enabled, (out_valid_reg && (out_kind_reg == KIND_SAMPLE)),
        $onehot0(out_word_reg[12:5]), "more than one layer enabled in a sample word")

endmodule

@@ sv/led_cube_pwm_scan_driver_top.sv @@
// Top level of the multiplexed PWM scan driver for a 4x4x8 RGB LED cube.
//
// Input channel (in_valid/in_ready): one beat carries an action and an LED
// address (layer_z, column_x, row_y) plus red/green/blue intensities. A tick
// produces one 13-bit sample word for the parallel output stream; a read
// produces a reply with the stored intensities; a write or a fill produces
// no result beat. Output channel (out_valid/out_ready): reply_kind tells a
// sample word from a read reply; the unused fields are zero.
// Ticks, reads and writes sustain one beat per cycle while out_ready is high
// and no fill is running; the rate is set by the single read port of the
// frame store and the one command the back end issues per cycle. A fill
// sweeps the 128-entry frame store one entry per cycle, so it holds the back
// end for the whole sweep while input beats queue up.
// Reset clears the scan counters and marks every frame entry as unwritten,
// so the cube starts dark with no layer enabled and no clearing pass.
// When the receiver stalls, the output register holds its beat, the second
// stage and the two-entry command queue fill, and in_ready falls.
module led_cube_pwm_scan_driver_top
    import lcpsd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          action,
    input  logic [2:0]          layer_z,
    input  logic [1:0]          column_x,
    input  logic [1:0]          row_y,
    input  logic [COLOR_W-1:0]  red_in,
    input  logic [COLOR_W-1:0]  green_in,
    input  logic [COLOR_W-1:0]  blue_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                reply_kind,
    output logic [WORD_W-1:0]   sample_word,
    output logic [COLOR_W-1:0]  read_red,
    output logic [COLOR_W-1:0]  read_green,
    output logic [COLOR_W-1:0]  read_blue
);

    // Decoded command between the front end queue and the back end.
    logic                 cmd_valid;
    logic                 cmd_ready;
    cmd_t                 cmd;

    // Frame store ports, owned by the back end.
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [RGB_W-1:0]     ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [RGB_W-1:0]     ram_rdata;

    lcpsd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .layer_z   (layer_z),
        .column_x  (column_x),
        .row_y     (row_y),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Frame store: red in bits 23:16, green in 15:8, blue in 7:0.
    lcpsd_ram
    #(
        .WIDTH (RGB_W),
        .DEPTH (NUM_LEDS)
    )
    u_frame_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lcpsd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .reply_kind  (reply_kind),
        .sample_word (sample_word),
        .read_red    (read_red),
        .read_green  (read_green),
        .read_blue   (read_blue)
    );

endmodule

@@ tb/cube_scan_sb_pkg.sv @@
// Beat types and the predicting scoreboard for the LED cube scan driver testbench.
`timescale 1ns / 1ps

package cube_scan_sb_pkg;
    import lcpsd_pkg::*;

    localparam logic [WORD_W-1:0] LATCH_WORD = WORD_W'(16);
    localparam int ENABLE_LSB = 5;

    typedef struct packed {
        action_t              act;
        logic [2:0]           z;
        logic [1:0]           x;
        logic [1:0]           y;
        logic [COLOR_W-1:0]   red;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   blue;
    } cube_cmd_t;

    typedef struct packed {
        kind_t                kind;
        logic [WORD_W-1:0]    word;
        logic [COLOR_W-1:0]   red;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   blue;
    } cube_reply_t;

    class cube_frame_scoreboard;
        logic [RGB_W-1:0]    frame [NUM_LEDS];
        logic [WC_W-1:0]     words_sent;
        logic                clk_level;
        logic [SHIFT_W-1:0]  scan_pos;
        logic [SLOT_W-1:0]   sub_frame;
        logic [BRIGHT_W-1:0] bright;
        logic [LAYERS-1:0]   layer_on;
        logic [PREV_W-1:0]   last_layer;
        cube_reply_t         due_replies [$];
        int                  mismatches;
        int                  checked;
        int                  full_scans;
        int                  past_end_wraps;
        int                  bright_wraps;
        int                  act_count [4];

        function new();
            foreach (frame[i])
            begin
                frame[i] = '0;
            end
            words_sent = '0;
            clk_level  = 1'b0;
            scan_pos   = '0;
            sub_frame  = '0;
            bright     = '0;
            layer_on   = '0;
            last_layer = PREV_W'(32);
            mismatches = 0;
            checked    = 0;
            full_scans = 0;
            past_end_wraps = 0;
            bright_wraps   = 0;
            foreach (act_count[i])
            begin
                act_count[i] = 0;
            end
        endfunction

        // Frame address of the LED shifted out at a 7-bit scan position.
        function logic [ADDR_W-1:0] led_at(logic [6:0] pos);
            logic [2:0] z;
            case (pos[3:2])
                2'd0:    z = 3'd2;
                2'd1:    z = 3'd6;
                2'd2:    z = 3'd4;
                default: z = 3'd0;
            endcase
            z = z + {2'b00, pos[6]};
            return {z, pos[5:4], pos[1:0]};
        endfunction

        // Advances the scan by one tick and returns the word it puts on the stream.
        function logic [WORD_W-1:0] scan_next_word();
            logic [WORD_W-1:0] w;
            logic [RGB_W-1:0]  led;
            logic [2:0]        layer;
            w = '0;
            if (words_sent < DATA_WORDS)
            begin
                if (scan_pos == SHIFT_W'(128))
                    past_end_wraps++;
                led = frame[led_at(scan_pos[6:0])];
                w[0] = clk_level;
                w[1] = ({4'b0, bright} < led[23:16]);
                w[2] = ({4'b0, bright} < led[15:8]);
                w[3] = ({4'b0, bright} < led[7:0]);
                w[ENABLE_LSB +: LAYERS] = layer_on;
                if (!clk_level)
                    clk_level = 1'b1;
                else
                begin
                    clk_level = 1'b0;
                    scan_pos  = scan_pos + 1'b1;
                end
            end
            else
            begin
                sub_frame = sub_frame + 1'b1;
                if (sub_frame == '0)
                    full_scans++;
                layer      = sub_frame[6:4];
                scan_pos   = {1'b0, layer, 4'b0000};
                layer_on   = LAYERS'(1) << layer;
                words_sent = '0;
                clk_level  = 1'b0;
                if (last_layer != PREV_W'(layer))
                begin
                    last_layer = PREV_W'(layer);
                    bright     = '0;
                    w          = LATCH_WORD;
                end
                else
                begin
                    if (bright == '1)
                        bright_wraps++;
                    bright = bright + 1'b1;
                    w = LATCH_WORD;
                    w[ENABLE_LSB +: LAYERS] = layer_on;
                end
            end
            words_sent = words_sent + 1'b1;
            return w;
        endfunction

        function void note_cmd(cube_cmd_t c);
            cube_reply_t r;
            logic [ADDR_W-1:0] addr;
            addr = {c.z, c.x, c.y};
            r = '0;
            act_count[int'(c.act)]++;
            case (c.act)
                ACT_TICK:
                begin
                    r.kind = KIND_SAMPLE;
                    r.word = scan_next_word();
                    due_replies.push_back(r);
                end
                ACT_WRITE:
                    frame[addr] = {c.red, c.green, c.blue};
                ACT_READ:
                begin
                    r.kind  = KIND_READ;
                    r.red   = frame[addr][23:16];
                    r.green = frame[addr][15:8];
                    r.blue  = frame[addr][7:0];
                    due_replies.push_back(r);
                end
                default:
                    foreach (frame[i])
                    begin
                        frame[i] = {c.red, c.green, c.blue};
                    end
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
            if (seen !== want)
            begin
                mismatches++;
                $error("%s: expected %0h, got %0h", name, want, seen);
            end
        endfunction

        function void check_reply(cube_reply_t got);
            cube_reply_t want;
            if (due_replies.size() == 0)
            begin
                mismatches++;
                $error("reply beat with nothing outstanding (kind %0h word %0h)",
                       got.kind, got.word);
                return;
            end
            want = due_replies.pop_front();
            checked++;
            compare_field("reply_kind", want.kind, got.kind);
            compare_field("sample_word", want.word, got.word);
            compare_field("read_red", want.red, got.red);
            compare_field("read_green", want.green, got.green);
            compare_field("read_blue", want.blue, got.blue);
        endfunction
    endclass

endpackage

@@ tb/tb_top.sv @@
// Top module of the LED cube scan driver testbench: clock, reset, drivers and run control.
`timescale 1ns / 1ps

module tb_top;
    import lcpsd_pkg::*;
    import cube_scan_sb_pkg::*;

    // A fill holds the back end for a full sweep of the frame; stall bursts on
    // top of that still leave this far away from a correct run.
    localparam int QUIET_LIMIT   = 2000;
    localparam int MIN_RANDOM    = 1480;
    localparam int CALM_TAIL     = 200;
    localparam int SETTLE_CYCLES = 8;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic [1:0]         action     = '0;
    logic [2:0]         layer_z    = '0;
    logic [1:0]         column_x   = '0;
    logic [1:0]         row_y      = '0;
    logic [COLOR_W-1:0] red_in     = '0;
    logic [COLOR_W-1:0] green_in   = '0;
    logic [COLOR_W-1:0] blue_in    = '0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic               reply_kind;
    logic [WORD_W-1:0]  sample_word;
    logic [COLOR_W-1:0] read_red;
    logic [COLOR_W-1:0] read_green;
    logic [COLOR_W-1:0] read_blue;

    // Random idling on both channels is enabled until the closing stretch.
    bit                 stress_on    = 1'b1;
    int                 stall_left   = 0;
    int                 quiet_cycles = 0;
    cube_reply_t        seen_reply;
    cube_frame_scoreboard sb;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    led_cube_pwm_scan_driver_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .layer_z     (layer_z),
        .column_x    (column_x),
        .row_y       (row_y),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .reply_kind  (reply_kind),
        .sample_word (sample_word),
        .read_red    (read_red),
        .read_green  (read_green),
        .read_blue   (read_blue)
    );

    // Output side. Signals are read right after the rising edge, before any
    // nonblocking update of that edge lands, so a beat is taken exactly when
    // out_valid and out_ready were both high going into the edge. The same
    // block then decides out_ready for the next cycle, with random stall
    // bursts while stress is on.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_reply.kind  = kind_t'(reply_kind);
            seen_reply.word  = sample_word;
            seen_reply.red   = read_red;
            seen_reply.green = read_green;
            seen_reply.blue  = read_blue;
            sb.check_reply(seen_reply);
        end
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (stress_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 3) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Watchdog: a long run of cycles with no beat on either channel means the
    // block has hung or dropped something.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic cube_cmd_t make_cmd(action_t a, int z, int x, int y,
                                           int r, int g, int b);
        cube_cmd_t c;
        c.act   = a;
        c.z     = 3'(z);
        c.x     = 2'(x);
        c.y     = 2'(y);
        c.red   = COLOR_W'(r);
        c.green = COLOR_W'(g);
        c.blue  = COLOR_W'(b);
        return c;
    endfunction

    // Intensities lean toward the 0..17 band, which covers the 1..15 range where
    // the 4-bit brightness slot actually decides whether a colour bit is lit.
    function automatic logic [COLOR_W-1:0] rand_level();
        logic [COLOR_W-1:0] v;
        case ($urandom_range(0, 3))
            0:       v = COLOR_W'($urandom_range(0, 17));
            1:       v = COLOR_W'($urandom_range(0, 17));
            2:       v = ($urandom_range(0, 1) == 1) ? '1 : '0;
            default: v = COLOR_W'($urandom);
        endcase
        return v;
    endfunction

    // Mostly ticks so the scan walks through whole sub-frames and layers;
    // writes and reads are sprinkled in and fills are rare since each one
    // stalls the back end for a full sweep of the frame.
    function automatic cube_cmd_t random_cmd();
        cube_cmd_t   c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            c.act = ACT_TICK;
        else if (pick < 91)
            c.act = ACT_WRITE;
        else if (pick < 99)
            c.act = ACT_READ;
        else
            c.act = ACT_FILL;
        c.z     = 3'($urandom);
        c.x     = 2'($urandom);
        c.y     = 2'($urandom);
        c.red   = rand_level();
        c.green = rand_level();
        c.blue  = rand_level();
        return c;
    endfunction

    // Presents one beat and waits for the block to take it. An optional gap
    // drops in_valid first; otherwise valid stays high straight into the
    // next beat, with a single nonblocking write per signal per edge.
    task automatic push_cmd(input cube_cmd_t c);
        if (stress_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= c.act;
        layer_z  <= c.z;
        column_x <= c.x;
        row_y    <= c.y;
        red_in   <= c.red;
        green_in <= c.green;
        blue_in  <= c.blue;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_cmd(c);
    endtask

    initial
    begin
        int issued;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening. Reads of untouched LEDs must come back dark, and
        // the first ticks after reset carry no layer enable. Then the LED at
        // scan position 0 and the address extremes are written and read,
        // fills at full and zero intensity are checked, and a low-level LED
        // in layer 6 is placed where the scan picks it up a few words later.
        push_cmd(make_cmd(ACT_READ,  0, 0, 0, 0, 0, 0));
        push_cmd(make_cmd(ACT_READ,  7, 3, 3, 0, 0, 0));
        push_cmd(make_cmd(ACT_TICK,  0, 0, 0, 0, 0, 0));
        push_cmd(make_cmd(ACT_TICK,  7, 3, 3, 255, 255, 255));
        push_cmd(make_cmd(ACT_WRITE, 2, 0, 0, 255, 1, 0));
        push_cmd(make_cmd(ACT_WRITE, 0, 0, 0, 255, 255, 255));
        push_cmd(make_cmd(ACT_WRITE, 7, 3, 3, 0, 128, 255));
        push_cmd(make_cmd(ACT_READ,  2, 0, 0, 0, 0, 0));
        push_cmd(make_cmd(ACT_READ,  0, 0, 0, 0, 0, 0));
        push_cmd(make_cmd(ACT_READ,  7, 3, 3, 0, 0, 0));
        push_cmd(make_cmd(ACT_TICK,  0, 0, 0, 0, 0, 0));
        push_cmd(make_cmd(ACT_TICK,  0, 0, 0, 0, 0, 0));
        push_cmd(make_cmd(ACT_TICK,  0, 0, 0, 0, 0, 0));
        push_cmd(make_cmd(ACT_FILL,  3, 2, 1, 255, 255, 255));
        push_cmd(make_cmd(ACT_READ,  5, 2, 1, 0, 0, 0));
        push_cmd(make_cmd(ACT_TICK,  0, 0, 0, 0, 0, 0));
        push_cmd(make_cmd(ACT_TICK,  0, 0, 0, 0, 0, 0));
        push_cmd(make_cmd(ACT_FILL,  4, 1, 2, 0, 0, 0));
        push_cmd(make_cmd(ACT_READ,  3, 1, 2, 0, 0, 0));
        push_cmd(make_cmd(ACT_WRITE, 6, 0, 0, 16, 15, 1));
        push_cmd(make_cmd(ACT_TICK,  0, 0, 0, 0, 0, 0));
        push_cmd(make_cmd(ACT_READ,  6, 0, 0, 0, 0, 0));
        push_cmd(make_cmd(ACT_TICK,  0, 0, 0, 0, 0, 0));
        push_cmd(make_cmd(ACT_TICK,  0, 0, 0, 0, 0, 0));

        // Random part. A fixed number of beats, mostly ticks, so the scan
        // runs through many sub-frames, the start-up layer and the first
        // layer changes.
        issued = 0;
        while (issued < MIN_RANDOM)
        begin
            push_cmd(random_cmd());
            issued++;
        end

        // Closing stretch at full rate on both channels.
        stress_on = 1'b0;
        repeat (CALM_TAIL) push_cmd(random_cmd());
        in_valid <= 1'b0;

        while (sb.due_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Beats in: %0d ticks, %0d writes, %0d reads, %0d fills; %0d replies checked.",
                 sb.act_count[0], sb.act_count[1], sb.act_count[2], sb.act_count[3],
                 sb.checked);
        $display("Scan reached %0d full cube passes, %0d brightness wraps, %0d past-end words.",
                 sb.full_scans, sb.bright_wraps, sb.past_end_wraps);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/lcpsd_pkg.sv
sv/lcpsd_ram.sv
sv/lcpsd_front.sv
sv/lcpsd_back.sv
sv/led_cube_pwm_scan_driver_top.sv
tb/cube_scan_sb_pkg.sv
tb/tb_top.sv
